### src/ffba_pkg.sv
package ffba_pkg;

  // pool geometry
  localparam int unsigned POOL_BYTES     = 65536;
  localparam int unsigned HEADER_BYTES   = 20;
  localparam int unsigned MAX_BLOCKS_DEF = 64;

  // field widths
  localparam int unsigned SIZE_W = 17;
  localparam int unsigned ADDR_W = 16;
  localparam int unsigned USED_W = 17;
  localparam int unsigned SUM_W  = 19;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_ALLOC = 2'd2,
    ST_ZERO      = 2'd3
  } status_t;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH,
    S_REPLY
  } ctrl_state_t;

  typedef struct packed {
    opcode_t             opcode;
    logic [SIZE_W-1:0]   request_size;
    logic [ADDR_W-1:0]   free_address;
  } req_item_t;

  typedef struct packed {
    status_t             status;
    logic [ADDR_W-1:0]   user_address;
  } rsp_item_t;

  // one block table entry: user offset and capacity
  typedef struct packed {
    logic [ADDR_W-1:0] user_addr;
    logic [ADDR_W-1:0] capacity;
  } entry_t;

  // table controls from the sequencer
  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic set_taken;
    logic clr_taken;
  } tbl_ctl_t;

  // outcome of the compare unit for one entry
  typedef struct packed {
    logic    hit;
    status_t status;
  } match_t;

endpackage

### src/ffba_table.sv
module ffba_table
  import ffba_pkg::*;
#(
  parameter int unsigned MAX_BLOCKS = MAX_BLOCKS_DEF,
  localparam int unsigned IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1
) (
  input  logic             clk,
  input  logic             rst,
  input  tbl_ctl_t         ctl,
  input  logic [IDX_W-1:0] rd_idx,
  input  logic [IDX_W-1:0] wr_idx,
  input  entry_t           wr_data,
  input  logic [IDX_W-1:0] upd_idx,
  input  logic [IDX_W-1:0] taken_idx,
  output entry_t           rd_data,
  output logic             rd_taken
);

  entry_t                mem [MAX_BLOCKS];
  logic [MAX_BLOCKS-1:0] taken;

  // block table memory, registered read
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_idx] <= wr_data;
    end
    if (ctl.rd_en) begin
      rd_data <= mem[rd_idx];
    end
  end

  // taken marks, cleared by reset
  always_ff @(posedge clk) begin
    if (rst) begin
      taken <= '0;
    end else if (ctl.set_taken) begin
      taken[upd_idx] <= 1'b1;
    end else if (ctl.clr_taken) begin
      taken[upd_idx] <= 1'b0;
    end
  end

  assign rd_taken = taken[taken_idx];

endmodule

### src/ffba_match.sv
module ffba_match
  import ffba_pkg::*;
(
  input  opcode_t           opcode,
  input  logic [SIZE_W-1:0] request_size,
  input  logic [ADDR_W-1:0] free_address,
  input  entry_t            entry,
  input  logic              taken,
  output match_t            match
);

  // first-fit test for allocate, address lookup for free
  always_comb begin
    match.hit    = 1'b0;
    match.status = ST_DONE;
    case (opcode)
      OP_ALLOC: begin
        match.hit    = !taken && ({1'b0, entry.capacity} >= request_size);
        match.status = ST_DONE;
      end
      OP_FREE: begin
        match.hit    = (entry.user_addr == free_address);
        match.status = taken ? ST_DONE : ST_NOT_ALLOC;
      end
      default: begin
        match.hit    = 1'b0;
        match.status = ST_DONE;
      end
    endcase
  end

endmodule

### src/ffba_ctrl.sv
module ffba_ctrl
  import ffba_pkg::*;
#(
  parameter int unsigned MAX_BLOCKS = MAX_BLOCKS_DEF,
  localparam int unsigned IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1,
  localparam int unsigned CNT_W = $clog2(MAX_BLOCKS + 1)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  req_item_t         req,
  output logic              res_valid,
  input  logic              res_ready,
  output rsp_item_t         res,
  output tbl_ctl_t          ctl,
  output logic [IDX_W-1:0]  rd_addr,
  output logic [IDX_W-1:0]  wr_idx,
  output entry_t            wr_data,
  output logic [IDX_W-1:0]  upd_idx,
  output logic [IDX_W-1:0]  chk_idx,
  output opcode_t           op,
  output logic [SIZE_W-1:0] size,
  output logic [ADDR_W-1:0] faddr,
  input  entry_t            rd_data,
  input  match_t            match
);

  ctrl_state_t       state, state_next;
  opcode_t           op_next;
  logic [SIZE_W-1:0] size_next;
  logic [ADDR_W-1:0] faddr_next;
  logic [CNT_W-1:0]  rd_idx, rd_idx_next;
  logic              chk_valid, chk_valid_next;
  logic [IDX_W-1:0]  chk_idx_next;
  logic [CNT_W-1:0]  count, count_next;
  logic [USED_W-1:0] used, used_next;
  status_t           res_status, res_status_next;
  logic [ADDR_W-1:0] res_addr, res_addr_next;

  logic [SUM_W-1:0]  need_first;
  logic [SUM_W-1:0]  need_next;
  logic              pool_empty;
  logic              no_room;
  logic              last_chk;
  logic              issue;

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      used      <= '0;
      chk_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      used      <= used_next;
      chk_valid <= chk_valid_next;
    end
  end

  // item and scan registers
  always_ff @(posedge clk) begin
    op         <= op_next;
    size       <= size_next;
    faddr      <= faddr_next;
    rd_idx     <= rd_idx_next;
    chk_idx    <= chk_idx_next;
    res_status <= res_status_next;
    res_addr   <= res_addr_next;
  end

  // append sizing: one add chain and compare
  assign need_first = SUM_W'(size) + SUM_W'(HEADER_BYTES);
  assign need_next  = need_first + SUM_W'(used);
  assign pool_empty = (count == '0);
  assign no_room    = (count == CNT_W'(MAX_BLOCKS)) ||
                      (pool_empty ? (need_first > SUM_W'(POOL_BYTES))
                                  : (need_next >= SUM_W'(POOL_BYTES)));
  assign last_chk   = ((CNT_W'(chk_idx) + CNT_W'(1)) == count);
  assign issue      = (rd_idx < count);

  assign rd_addr   = rd_idx[IDX_W-1:0];
  assign req_stall = (state != S_IDLE);
  assign res_valid = (state == S_REPLY);
  assign res       = '{status: res_status, user_address: res_addr};

  // sequencer
  always_comb begin
    state_next      = state;
    op_next         = op;
    size_next       = size;
    faddr_next      = faddr;
    rd_idx_next     = rd_idx;
    chk_valid_next  = 1'b0;
    chk_idx_next    = chk_idx;
    count_next      = count;
    used_next       = used;
    res_status_next = res_status;
    res_addr_next   = res_addr;
    ctl             = '0;
    wr_idx          = count[IDX_W-1:0];
    upd_idx         = chk_idx;
    wr_data.user_addr = (pool_empty ? ADDR_W'(0) : used[ADDR_W-1:0]) + ADDR_W'(HEADER_BYTES);
    wr_data.capacity  = size[ADDR_W-1:0];
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          op_next         = req.opcode;
          size_next       = req.request_size;
          faddr_next      = req.free_address;
          rd_idx_next     = '0;
          res_addr_next   = '0;
          res_status_next = ST_DONE;
          if (req.opcode == OP_ALLOC && req.request_size == '0) begin
            res_status_next = ST_ZERO;
            state_next      = S_REPLY;
          end else if (pool_empty) begin
            state_next = S_FINISH;
          end else begin
            state_next = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        // one table read issued, one entry checked per cycle
        ctl.rd_en      = issue;
        chk_valid_next = issue;
        chk_idx_next   = rd_idx[IDX_W-1:0];
        if (issue) begin
          rd_idx_next = rd_idx + CNT_W'(1);
        end
        if (chk_valid) begin
          if (match.hit) begin
            res_status_next = match.status;
            chk_valid_next  = 1'b0;
            if (op == OP_ALLOC) begin
              ctl.set_taken = 1'b1;
              res_addr_next = rd_data.user_addr;
            end else if (match.status == ST_DONE) begin
              ctl.clr_taken = 1'b1;
            end
            state_next = S_REPLY;
          end else if (last_chk) begin
            chk_valid_next = 1'b0;
            state_next     = S_FINISH;
          end
        end
      end
      S_FINISH: begin
        // no entry matched: append or report failure
        if (op == OP_FREE) begin
          res_status_next = ST_NOT_ALLOC;
        end else if (no_room) begin
          res_status_next = ST_FULL;
        end else begin
          ctl.wr_en       = 1'b1;
          ctl.set_taken   = 1'b1;
          upd_idx         = count[IDX_W-1:0];
          count_next      = count + CNT_W'(1);
          used_next       = pool_empty ? USED_W'(need_first) : USED_W'(need_next);
          res_status_next = ST_DONE;
          res_addr_next   = wr_data.user_addr;
        end
        state_next = S_REPLY;
      end
      S_REPLY: begin
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

### src/first_fit_block_allocator.sv
// a zero-size request goes from accept straight to the reply; other requests
// scan the block table entries in order, then append or report failure if none matched
// throughput: one item at a time; the next item is taken once the result has
// moved into the result register and the sequencer is back in idle
// the result register frees the sequencer while the result waits to be taken
// reset (rst, synchronous): pool empty, all taken marks clear, no result pending
module first_fit_block_allocator
  import ffba_pkg::*;
#(
  parameter int unsigned MAX_BLOCKS = MAX_BLOCKS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_stall,
  input  req_item_t req,
  output logic      rsp_valid,
  input  logic      rsp_stall,
  output rsp_item_t rsp
);

  localparam int unsigned IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;

  tbl_ctl_t          ctl;
  logic [IDX_W-1:0]  rd_idx;
  logic [IDX_W-1:0]  wr_idx;
  logic [IDX_W-1:0]  upd_idx;
  logic [IDX_W-1:0]  chk_idx;
  entry_t            wr_data;
  entry_t            rd_data;
  logic              rd_taken;
  match_t            match;
  logic              res_valid;
  logic              res_ready;
  rsp_item_t         res;
  opcode_t           op;
  logic [SIZE_W-1:0] size;
  logic [ADDR_W-1:0] faddr;

  ffba_ctrl #(.MAX_BLOCKS(MAX_BLOCKS)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .ctl       (ctl),
    .rd_addr   (rd_idx),
    .wr_idx    (wr_idx),
    .wr_data   (wr_data),
    .upd_idx   (upd_idx),
    .chk_idx   (chk_idx),
    .op        (op),
    .size      (size),
    .faddr     (faddr),
    .rd_data   (rd_data),
    .match     (match)
  );

  ffba_table #(.MAX_BLOCKS(MAX_BLOCKS)) u_table (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .rd_idx    (rd_idx),
    .wr_idx    (wr_idx),
    .wr_data   (wr_data),
    .upd_idx   (upd_idx),
    .taken_idx (chk_idx),
    .rd_data   (rd_data),
    .rd_taken  (rd_taken)
  );

  ffba_match u_match (
    .opcode       (op),
    .request_size (size),
    .free_address (faddr),
    .entry        (rd_data),
    .taken        (rd_taken),
    .match        (match)
  );

  // result register
  assign res_ready = !rsp_valid || !rsp_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_ready) begin
      rsp_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      rsp <= res;
    end
  end

endmodule

### sim/first_fit_block_allocator_test.sv
`timescale 1ns / 1ps

module first_fit_block_allocator_test
  import ffba_pkg::*;
();

  localparam int unsigned CYCLE_LIMIT = 500000;

  typedef enum int unsigned {
    STALL_NONE,
    STALL_SPARSE,
    STALL_RUNS
  } stall_mode_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      req_valid = 1'b0;
  logic      req_stall;
  req_item_t req = '0;
  logic      rsp_valid;
  logic      rsp_stall = 1'b0;
  rsp_item_t rsp;

  // shadow copy of the block table
  bit [ADDR_W-1:0] blk_start [MAX_BLOCKS_DEF];
  bit [ADDR_W-1:0] blk_cap [MAX_BLOCKS_DEF];
  bit              blk_taken [MAX_BLOCKS_DEF];
  int unsigned     blk_count = 0;
  int unsigned     pool_used = 0;

  rsp_item_t   pending_replies[$];
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;

  // sender burst shaping
  int unsigned burst_left = 0;
  bit          steady = 1'b0;

  // receiver stall pattern
  int unsigned stall_seg = 0;
  int unsigned stall_run = 0;
  stall_mode_t stall_mode = STALL_NONE;

  first_fit_block_allocator dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // user offset of table entry k
  function automatic logic [ADDR_W-1:0] user_offset(input int unsigned k);
    int unsigned sum;
    sum = int'(blk_start[k]) + HEADER_BYTES;
    return sum[ADDR_W-1:0];
  endfunction

  function automatic void append_block(input int unsigned start, input int unsigned bytes);
    int unsigned end_off;
    blk_start[blk_count] = start[ADDR_W-1:0];
    blk_cap[blk_count]   = bytes[ADDR_W-1:0];
    blk_taken[blk_count] = 1'b1;
    blk_count++;
    end_off = (start + HEADER_BYTES + bytes) & 32'h1FFFF;
    pool_used = end_off;
  endfunction

  // expected reply for one accepted item, updating the shadow table
  function automatic rsp_item_t predict_reply(input req_item_t item);
    rsp_item_t   reply;
    int unsigned need;
    int unsigned k;
    bit          hit;
    reply.status       = ST_DONE;
    reply.user_address = '0;
    hit  = 1'b0;
    need = 32'(item.request_size);
    if (item.opcode == OP_ALLOC) begin
      if (need == 0) begin
        reply.status = ST_ZERO;
      end else if (blk_count == 0) begin
        // the first block may take the whole pool
        if (need + HEADER_BYTES > POOL_BYTES) begin
          reply.status = ST_FULL;
        end else begin
          append_block(0, need);
          reply.user_address = user_offset(0);
        end
      end else begin
        // first fit over existing blocks, no split
        for (k = 0; k < blk_count; k++) begin
          if (!hit && !blk_taken[k] && blk_cap[k] >= need) begin
            hit = 1'b1;
            blk_taken[k] = 1'b1;
            reply.user_address = user_offset(k);
          end
        end
        if (!hit) begin
          if (blk_count >= MAX_BLOCKS_DEF) begin
            reply.status = ST_FULL;
          end else if (need + HEADER_BYTES + pool_used >= POOL_BYTES) begin
            reply.status = ST_FULL;
          end else begin
            k = blk_count;
            append_block(pool_used, need);
            reply.user_address = user_offset(k);
          end
        end
      end
    end else begin
      // free: first entry with matching user offset decides
      reply.status = ST_NOT_ALLOC;
      for (k = 0; k < blk_count; k++) begin
        if (!hit && user_offset(k) == item.free_address) begin
          hit = 1'b1;
          if (blk_taken[k]) begin
            blk_taken[k] = 1'b0;
            reply.status = ST_DONE;
          end
        end
      end
    end
    return reply;
  endfunction

  // random user offset of a taken (or free) block, -1 if none
  function automatic int pick_block_user(input bit want_taken);
    int unsigned hits;
    int unsigned choice;
    int unsigned k;
    hits = 0;
    for (k = 0; k < blk_count; k++) begin
      if (blk_taken[k] == want_taken) hits++;
    end
    if (hits == 0) return -1;
    choice = $urandom_range(0, hits - 1);
    for (k = 0; k < blk_count; k++) begin
      if (blk_taken[k] == want_taken) begin
        if (choice == 0) return int'(user_offset(k));
        choice--;
      end
    end
    return -1;
  endfunction

  function automatic int unsigned max_free_cap();
    int unsigned best;
    int unsigned k;
    best = 0;
    for (k = 0; k < blk_count; k++) begin
      if (!blk_taken[k] && blk_cap[k] > best) best = 32'(blk_cap[k]);
    end
    return best;
  endfunction

  function automatic int unsigned pick_gap();
    if (steady) return 0;
    if (burst_left != 0) begin
      burst_left--;
      return 0;
    end
    burst_left = $urandom_range(0, 15);
    return $urandom_range(1, 6);
  endfunction

  function automatic int unsigned random_size();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 80) return $urandom_range(1, 256);
    if (roll < 97) return $urandom_range(257, 1024);
    return $urandom_range(1, 8);
  endfunction

  task automatic report_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
    $display("mismatch %s: expected %0d got %0d at %0t", what, want, got, $realtime);
    error_count++;
  endtask

  // drive one item and hold it until accepted
  task automatic send_request(input opcode_t op, input int unsigned size,
                              input int unsigned addr);
    req_item_t   item;
    int unsigned gap;
    item.opcode       = op;
    item.request_size = size[SIZE_W-1:0];
    item.free_address = addr[ADDR_W-1:0];
    req       <= item;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall);
    pending_replies.push_back(predict_reply(item));
    gap = pick_gap();
    if (gap != 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_for_replies();
    req_valid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
  endtask

  // reply checker
  always @(posedge clk) begin
    rsp_item_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (pending_replies.size() == 0) begin
        report_mismatch("reply with none pending", 0, int'(rsp.status));
      end else begin
        want = pending_replies.pop_front();
        if (rsp.status !== want.status)
          report_mismatch("status", int'(want.status), int'(rsp.status));
        if (rsp.user_address !== want.user_address)
          report_mismatch("user_address", 32'(want.user_address), 32'(rsp.user_address));
      end
    end
  end

  // receiver stall pattern: segments of no stall, sparse stalls, stall runs
  always @(posedge clk) begin
    if (stall_seg == 0) begin
      stall_seg  = $urandom_range(20, 200);
      stall_mode = stall_mode_t'($urandom_range(0, 2));
    end else begin
      stall_seg--;
    end
    case (stall_mode)
      STALL_NONE: begin
        rsp_stall <= 1'b0;
      end
      STALL_SPARSE: begin
        rsp_stall <= ($urandom_range(0, 2) == 0);
      end
      default: begin
        if (stall_run != 0) begin
          stall_run--;
          rsp_stall <= 1'b1;
        end else begin
          stall_run = $urandom_range(1, 8);
          rsp_stall <= 1'b0;
        end
      end
    endcase
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // requests against the empty pool
  task automatic test_empty_pool();
    send_request(OP_FREE, 0, 0);
    send_request(OP_FREE, 65536, HEADER_BYTES);
    send_request(OP_ALLOC, 0, 16'hFFFF);
    send_request(OP_ALLOC, 65536, 0);
    // one byte more than the pool holds with its header
    send_request(OP_ALLOC, POOL_BYTES - HEADER_BYTES + 1, 16'h5A5A);
    send_request(OP_FREE, 65536, 16'hFFFF);
  endtask

  // first blocks, reuse without split, double free, ignored fields
  task automatic test_reuse_without_split();
    send_request(OP_ALLOC, 1, 16'hFFFF);
    send_request(OP_ALLOC, 100, 0);
    send_request(OP_FREE, 0, 41);
    send_request(OP_FREE, 0, 41);
    send_request(OP_ALLOC, 50, 41);
    send_request(OP_ALLOC, 101, 0);
    send_request(OP_FREE, 0, 40);
    send_request(OP_FREE, 0, 16'hFFFF);
    send_request(OP_FREE, 65536, HEADER_BYTES);
    send_request(OP_ALLOC, 1, 0);
    send_request(OP_FREE, 0, HEADER_BYTES);
    send_request(OP_ALLOC, 2, 16'hAAAA);
    send_request(OP_ALLOC, 0, 16'h5555);
    wait_for_replies();
  endtask

  // mostly well-formed alloc and free traffic, some noise
  task automatic test_random_traffic(input int unsigned items);
    int unsigned i;
    int unsigned roll;
    int unsigned best;
    int          a;
    bit          crowded;
    bit          sent;
    for (i = 0; i < items; i++) begin
      if (i == items / 4) steady = 1'b1;
      if (i == items / 4 + 60) steady = 1'b0;
      if (i == items / 2) wait_for_replies();
      // keep room for the table and pool limit tests
      crowded = (blk_count >= 48) || (pool_used >= 30000);
      roll = $urandom_range(0, 99);
      sent = 1'b0;
      if (roll < 45) begin
        best = max_free_cap();
        if (!crowded) begin
          send_request(OP_ALLOC, random_size(), $urandom);
          sent = 1'b1;
        end else if (best != 0) begin
          send_request(OP_ALLOC, $urandom_range(1, best), $urandom);
          sent = 1'b1;
        end
      end else if (roll >= 85) begin
        sent = 1'b1;
        if (roll < 90) begin
          a = pick_block_user(1'b0);
          if (a >= 0) send_request(OP_FREE, $urandom_range(0, 65536), a);
          else send_request(OP_FREE, $urandom_range(0, 65536), $urandom);
        end else if (roll < 97) begin
          send_request(OP_FREE, $urandom_range(0, 65536), $urandom);
        end else if (roll < 98) begin
          send_request(OP_ALLOC, 0, $urandom);
        end else begin
          send_request(OP_ALLOC, $urandom_range(POOL_BYTES - HEADER_BYTES + 1, 65536),
                       $urandom);
        end
      end
      if (!sent) begin
        a = pick_block_user(1'b1);
        if (a >= 0) send_request(OP_FREE, $urandom_range(0, 65536), a);
        else if (!crowded) send_request(OP_ALLOC, random_size(), $urandom);
        else send_request(OP_FREE, $urandom_range(0, 65536), $urandom);
      end
    end
    wait_for_replies();
  endtask

  // fill the table, hit the strict pool edge, then the full table
  task automatic test_table_and_pool_limits();
    int unsigned k;
    int unsigned last_bytes;
    int          a;
    bit          found;
    // take every free block so that new sizes append
    found = 1'b1;
    while (found) begin
      found = 1'b0;
      for (k = 0; k < blk_count; k++) begin
        if (!found && !blk_taken[k]) begin
          found = 1'b1;
          last_bytes = 32'(blk_cap[k]);
        end
      end
      if (found) send_request(OP_ALLOC, last_bytes, $urandom);
    end
    while (blk_count < MAX_BLOCKS_DEF - 1) send_request(OP_ALLOC, $urandom_range(1, 40), 0);
    // last block: end offset equal to the pool fails, one less fits
    last_bytes = POOL_BYTES - 1 - HEADER_BYTES - pool_used;
    send_request(OP_ALLOC, last_bytes + 1, 0);
    send_request(OP_ALLOC, last_bytes, 0);
    // table full with nothing free
    send_request(OP_ALLOC, 1, 0);
    a = pick_block_user(1'b1);
    send_request(OP_FREE, 0, a);
    send_request(OP_ALLOC, 65535, 0);
    send_request(OP_ALLOC, 1, 0);
    wait_for_replies();
  endtask

  // traffic over a full table: longest scans
  task automatic test_full_table_traffic(input int unsigned items);
    int unsigned i;
    int          a;
    for (i = 0; i < items; i++) begin
      if ($urandom_range(0, 99) < 45) begin
        if ($urandom_range(0, 1) == 0) send_request(OP_ALLOC, $urandom_range(1, 64), $urandom);
        else send_request(OP_ALLOC, $urandom_range(1, 65536), $urandom);
      end else begin
        a = pick_block_user($urandom_range(0, 3) != 0);
        if (a >= 0) send_request(OP_FREE, $urandom_range(0, 65536), a);
        else send_request(OP_FREE, $urandom_range(0, 65536), $urandom);
      end
    end
    wait_for_replies();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_pool();
    test_reuse_without_split();
    test_random_traffic(560);
    test_table_and_pool_limits();
    test_full_table_traffic(60);
    wait_for_replies();
    repeat (MAX_BLOCKS_DEF + 16) @(posedge clk);
    if (error_count == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
